// File: sv/fpam_pkg.sv
// ----------------------------------------------------------------------------
// fpam_pkg
// Shared constants, codes and types of the adaptive-margin frame pacer.
// ----------------------------------------------------------------------------
package fpam_pkg;

    localparam int HISTORY_DEPTH_DEF = 128;

    localparam int TIME_W   = 48;
    localparam int LAT_W    = 32;
    localparam int RATE_W   = 10;
    localparam int PERIOD_W = 30;
    localparam int FAIL_W   = 11;
    localparam int ACT_W    = 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [ACT_W-1:0] ACT_PROCEED = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SLEEP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SPIN    = 2'd2;

    localparam logic CMD_PACE = 1'b0;
    localparam logic CMD_WAKE = 1'b1;

    localparam logic [1:0] REG_ENABLED = 2'd0;
    localparam logic [1:0] REG_RATE    = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [LAT_W-1:0]  lat_t;

endpackage

// File: sv/fpam_if.sv
// ----------------------------------------------------------------------------
// fpam_in_if / fpam_out_if
// Valid/ready channels carrying pacer requests and pacer results.
// ----------------------------------------------------------------------------
interface fpam_in_if;
    logic                   valid;
    logic                   ready;
    logic                   command;
    fpam_pkg::time_t        time_ns;

    modport source (output valid, output command, output time_ns, input ready);
    modport sink   (input valid, input command, input time_ns, output ready);
endinterface

interface fpam_out_if;
    logic                           valid;
    logic                           ready;
    logic [fpam_pkg::ACT_W-1:0]     action;
    fpam_pkg::lat_t                 wait_ns;
    fpam_pkg::time_t                deadline_ns;
    fpam_pkg::lat_t                 margin_ns;

    modport source (output valid, output action, output wait_ns, output deadline_ns,
                    output margin_ns, input ready);
    modport sink   (input valid, input action, input wait_ns, input deadline_ns,
                    input margin_ns, output ready);
endinterface

// File: sv/fpam_cell.sv
// ----------------------------------------------------------------------------
// fpam_cell
// One latency cell of the history chain; takes its neighbour's value on shift.
// ----------------------------------------------------------------------------
module fpam_cell
(
    input  logic           clk,
    input  logic           shift,
    input  fpam_pkg::lat_t din,
    output fpam_pkg::lat_t dout
);
    import fpam_pkg::*;

    lat_t value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

// File: sv/fpam_rank.sv
// ----------------------------------------------------------------------------
// fpam_rank
// Running top-list and minimum over the latencies streamed out of the chain.
// ----------------------------------------------------------------------------
module fpam_rank
#(
    parameter int SLOTS = 2,
    parameter int KW    = 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clr,
    input  logic           en,
    input  fpam_pkg::lat_t din,
    input  logic [KW-1:0]  k,
    output fpam_pkg::lat_t kth,
    output fpam_pkg::lat_t least
);
    import fpam_pkg::*;

    lat_t             top_reg [SLOTS];
    logic [SLOTS-1:0] tv_reg;
    lat_t             min_reg;
    logic [SLOTS-1:0] ge;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ge[i] = tv_reg[i] && (top_reg[i] >= din);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else if (clr)
        begin
            tv_reg <= '0;
        end
        else if (en)
        begin
            tv_reg <= (tv_reg << 1) | SLOTS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            min_reg <= '1;
        end
        else if (en)
        begin
            if (din < min_reg)
            begin
                min_reg <= din;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!ge[i])
                begin
                    if (i == 0)
                    begin
                        top_reg[i] <= din;
                    end
                    else if (ge[i-1])
                    begin
                        top_reg[i] <= din;
                    end
                    else
                    begin
                        top_reg[i] <= top_reg[i-1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        kth = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (k == KW'(i))
            begin
                kth = top_reg[i];
            end
        end
    end

    assign least = min_reg;

endmodule

// File: sv/frame_pacer_adaptive_margin.sv
// ----------------------------------------------------------------------------
// frame_pacer_adaptive_margin
// Frame pacer with a wake-latency history chain and an adaptive spin margin.
// ----------------------------------------------------------------------------
// One request at a time. A spin that ends a run of failures with history
// present adds a scan of the latency chain, followed by a margin-shrink
// step when the margin shrinks. A report of an outstanding sleep adds the
// same scan once the history is a tenth full. The scan rotates the latency
// chain once through the ranking unit, which tracks the largest few values
// and the minimum. Results wait in an output register, so a new request can
// be taken while one is pending; a stalled result holds the next one in its
// final state.
module frame_pacer_adaptive_margin
#(
    parameter int HISTORY_DEPTH = fpam_pkg::HISTORY_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpam_pkg::PADDR_W-1:0]  paddr,
    input  logic [fpam_pkg::PDATA_W-1:0]  pwdata,
    output logic [fpam_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    fpam_in_if.sink                       in_ch,
    fpam_out_if.source                    out_ch
);
    import fpam_pkg::*;

    localparam int FW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SW     = $clog2(HISTORY_DEPTH);
    localparam int SLOTS  = HISTORY_DEPTH / 100 + 1;
    localparam int KW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int THRESH = (HISTORY_DEPTH + 9) / 10;
    localparam int KPW    = FW + 13;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P0   = 4'd1;
    localparam logic [3:0] ST_P1   = 4'd2;
    localparam logic [3:0] ST_P2   = 4'd3;
    localparam logic [3:0] ST_W0   = 4'd4;
    localparam logic [3:0] ST_W1   = 4'd5;
    localparam logic [3:0] ST_W2   = 4'd6;
    localparam logic [3:0] ST_WF   = 4'd7;
    localparam logic [3:0] ST_SCAN = 4'd8;
    localparam logic [3:0] ST_FK   = 4'd9;
    localparam logic [3:0] ST_FS   = 4'd10;
    localparam logic [3:0] ST_SH   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    localparam logic MODE_KTH = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    logic [3:0]          state_reg;
    logic                mode_reg;
    logic                enabled_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [PERIOD_W-1:0] period_reg;
    time_t               t_reg;
    time_t               last_frame_reg;
    time_t               next_dl_reg;
    time_t               start_reg;
    time_t               work_reg;
    lat_t                planned_reg;
    lat_t                margin_reg;
    logic [FW-1:0]       fill_reg;
    logic [FAIL_W-1:0]   fail_reg;
    logic [RATE_W-1:0]   seen_rate_reg;
    logic [KW-1:0]       k_reg;
    logic [SW-1:0]       scan_cnt_reg;
    logic [63:0]         prod_reg;
    logic [ACT_W-1:0]    res_action_reg;
    lat_t                res_wait_reg;
    time_t               res_dl_reg;
    logic                out_valid_reg;
    logic [ACT_W-1:0]    out_action_reg;
    lat_t                out_wait_reg;
    time_t               out_dl_reg;
    lat_t                out_margin_reg;

    lat_t                cell_q [HISTORY_DEPTH];
    lat_t                cell_d [HISTORY_DEPTH];
    logic                chain_shift;
    logic                push;
    lat_t                lat_val;
    logic                rank_clr;
    logic                rank_en;
    lat_t                rank_kth;
    lat_t                rank_min;

    logic                cfg_wr;
    logic [TIME_W:0]     dl_sum;
    time_t               dl_sat;
    time_t               diff_wait;
    lat_t                wait_sat;
    logic [FAIL_W-1:0]   fail_inc;
    time_t               lat_wide;
    logic [FW-1:0]       fill_new;
    logic [KPW-1:0]      k_prod;
    logic [FW:0]         scan_pos;
    logic [LAT_W:0]      kth_margin;
    logic [LAT_W+1:0]    min_x3;
    lat_t                q10;
    lat_t                rem10;
    logic                out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLED: prdata = {31'd0, enabled_reg};
            REG_RATE:    prdata = {22'd0, rate_reg};
            REG_PERIOD:  prdata = {2'd0, period_reg};
            default:     prdata = '0;
        endcase
    end

    assign dl_sum    = {1'b0, last_frame_reg} + {19'd0, period_reg};
    assign dl_sat    = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
    assign diff_wait = work_reg - {16'd0, margin_reg};
    assign wait_sat  = (|diff_wait[47:32]) ? '1 : diff_wait[31:0];
    assign fail_inc  = fail_reg + 1'b1;
    assign lat_wide  = (work_reg > {16'd0, planned_reg}) ? work_reg - {16'd0, planned_reg}
                                                         : '0;
    assign lat_val   = (|lat_wide[47:32]) ? '1 : lat_wide[31:0];
    assign fill_new  = (fill_reg == FW'(HISTORY_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    assign k_prod    = KPW'(fill_reg) * KPW'(5243);
    assign scan_pos  = (FW+1)'(scan_cnt_reg) + (FW+1)'(fill_reg);
    assign kth_margin = {1'b0, rank_kth} + {2'b0, rank_kth[31:1]};
    assign min_x3    = {2'b0, rank_min} + {1'b0, rank_min, 1'b0};
    assign q10       = prod_reg[63:35] == '0 ? '0 : LAT_W'(prod_reg[63:35]);
    assign rem10     = margin_reg - ({q10[28:0], 3'b0} + {q10[30:0], 1'b0});
    assign out_free  = !out_valid_reg || out_ch.ready;

    assign push        = (state_reg == ST_W1);
    assign chain_shift = push || (state_reg == ST_SCAN);
    assign rank_en     = (state_reg == ST_SCAN) && (scan_pos >= (FW+1)'(HISTORY_DEPTH));
    assign rank_clr    = (state_reg == ST_W2) || (state_reg == ST_P2);

    assign cell_d[0] = push ? lat_val : cell_q[HISTORY_DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++)
        begin : g_chain
            if (gi > 0)
            begin : g_link
                assign cell_d[gi] = cell_q[gi-1];
            end
            fpam_cell u_cell
            (
                .clk   (clk),
                .shift (chain_shift),
                .din   (cell_d[gi]),
                .dout  (cell_q[gi])
            );
        end
    endgenerate

    fpam_rank #(.SLOTS(SLOTS), .KW(KW)) u_rank
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (rank_clr),
        .en    (rank_en),
        .din   (cell_q[HISTORY_DEPTH-1]),
        .k     (k_reg),
        .kth   (rank_kth),
        .least (rank_min)
    );

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.action      = out_action_reg;
    assign out_ch.wait_ns     = out_wait_reg;
    assign out_ch.deadline_ns = out_dl_reg;
    assign out_ch.margin_ns   = out_margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            rate_reg    <= '0;
            period_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENABLED: enabled_reg <= pwdata[0];
                REG_RATE:    rate_reg    <= pwdata[RATE_W-1:0];
                REG_PERIOD:  period_reg  <= pwdata[PERIOD_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_KTH;
            last_frame_reg <= '0;
            next_dl_reg    <= '0;
            start_reg      <= '0;
            planned_reg    <= '0;
            margin_reg     <= '0;
            fill_reg       <= '0;
            fail_reg       <= '0;
            seen_rate_reg  <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        t_reg     <= in_ch.time_ns;
                        state_reg <= (in_ch.command == CMD_WAKE) ? ST_W0 : ST_P0;
                    end
                end
                ST_P0:
                begin
                    if (!enabled_reg || rate_reg == '0)
                    begin
                        res_action_reg <= ACT_PROCEED;
                        res_wait_reg   <= '0;
                        res_dl_reg     <= t_reg;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        if (rate_reg != seen_rate_reg)
                        begin
                            margin_reg    <= '0;
                            fill_reg      <= '0;
                            seen_rate_reg <= rate_reg;
                        end
                        next_dl_reg <= dl_sat;
                        state_reg   <= ST_P1;
                    end
                end
                ST_P1:
                begin
                    res_wait_reg <= '0;
                    res_dl_reg   <= next_dl_reg;
                    if (t_reg >= next_dl_reg)
                    begin
                        last_frame_reg <= t_reg;
                        res_action_reg <= ACT_PROCEED;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        work_reg  <= next_dl_reg - t_reg;
                        state_reg <= ST_P2;
                    end
                end
                ST_P2:
                begin
                    if (work_reg > {16'd0, margin_reg})
                    begin
                        planned_reg    <= wait_sat;
                        start_reg      <= t_reg;
                        res_action_reg <= ACT_SLEEP;
                        res_wait_reg   <= wait_sat;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        res_action_reg <= ACT_SPIN;
                        last_frame_reg <= next_dl_reg;
                        if (fail_inc > {1'b0, rate_reg})
                        begin
                            fail_reg <= '0;
                            if (fill_reg == '0)
                            begin
                                margin_reg <= '0;
                                state_reg  <= ST_OUT;
                            end
                            else
                            begin
                                mode_reg     <= MODE_MIN;
                                scan_cnt_reg <= '0;
                                state_reg    <= ST_SCAN;
                            end
                        end
                        else
                        begin
                            fail_reg  <= fail_inc;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_W0:
                begin
                    if (planned_reg == '0)
                    begin
                        res_action_reg <= ACT_PROCEED;
                        res_wait_reg   <= '0;
                        res_dl_reg     <= next_dl_reg;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        work_reg  <= (t_reg > start_reg) ? t_reg - start_reg : '0;
                        state_reg <= ST_W1;
                    end
                end
                ST_W1:
                begin
                    fill_reg    <= fill_new;
                    fail_reg    <= '0;
                    planned_reg <= '0;
                    state_reg   <= ST_W2;
                end
                ST_W2:
                begin
                    if (fill_reg >= FW'(THRESH))
                    begin
                        k_reg        <= KW'(k_prod >> 19);
                        mode_reg     <= MODE_KTH;
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_WF;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == SW'(HISTORY_DEPTH - 1))
                    begin
                        state_reg <= (mode_reg == MODE_MIN) ? ST_FS : ST_FK;
                    end
                end
                ST_FK:
                begin
                    margin_reg <= kth_margin[LAT_W] ? '1 : kth_margin[LAT_W-1:0];
                    state_reg  <= ST_WF;
                end
                ST_WF:
                begin
                    res_wait_reg <= '0;
                    res_dl_reg   <= next_dl_reg;
                    if (t_reg < next_dl_reg)
                    begin
                        last_frame_reg <= next_dl_reg;
                        res_action_reg <= ACT_SPIN;
                    end
                    else
                    begin
                        last_frame_reg <= t_reg;
                        res_action_reg <= ACT_PROCEED;
                    end
                    state_reg <= ST_OUT;
                end
                ST_FS:
                begin
                    if (min_x3 < {3'd0, period_reg, 1'b0})
                    begin
                        prod_reg  <= 64'(margin_reg) * 64'(32'hCCCC_CCCD);
                        state_reg <= ST_SH;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_SH:
                begin
                    margin_reg <= margin_reg - (q10 + LAT_W'(rem10 != '0));
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_action_reg <= res_action_reg;
                        out_wait_reg   <= res_wait_reg;
                        out_dl_reg     <= res_dl_reg;
                        out_margin_reg <= margin_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/fpam_checker.sv
// ----------------------------------------------------------------------------
// fpam_checker
// Port-level checks on the pacer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fpam_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [fpam_pkg::ACT_W-1:0]   out_action,
    input fpam_pkg::lat_t               out_wait_ns,
    input logic                         pready
);
    import fpam_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_action == ACT_PROCEED || out_action == ACT_SLEEP ||
                       out_action == ACT_SPIN))
        else $error("bad action code");

    a_wait_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action == ACT_SLEEP |-> out_wait_ns != '0)
        else $error("sleep with zero wait");

    a_wait_other: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action != ACT_SLEEP |-> out_wait_ns == '0 && pready)
        else $error("wait set without sleep");

endmodule

bind frame_pacer_adaptive_margin fpam_checker u_fpam_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_action  (out_ch.action),
    .out_wait_ns (out_ch.wait_ns),
    .pready      (pready)
);

// File: tb/frame_pacer_adaptive_margin_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_pacer_adaptive_margin_test
// Drives pace requests and sleep-done reports through the frame pacer under
// several register settings and flow-control patterns. Each result is checked
// field by field against a cycle-free predictor of the pacer kept in a small
// scoreboard class.
// ----------------------------------------------------------------------------
module frame_pacer_adaptive_margin_test;
    import fpam_pkg::*;

    localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
    localparam int RING_DEPTH = HISTORY_DEPTH_DEF;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        lat_t             wait_ns;
        time_t            deadline_ns;
        lat_t             margin_ns;
    } pacer_result_t;

    class pacer_scoreboard;
        bit                 en;
        bit [RATE_W-1:0]    rate;
        bit [PERIOD_W-1:0]  period;
        longint unsigned    last_frame, next_dl, sleep_start;
        bit [31:0]          planned, margin;
        bit [31:0]          ring [RING_DEPTH];
        int                 wslot, fill, fails;
        bit [RATE_W-1:0]    seen_rate;
        pacer_result_t      pending [$];
        int                 errors, checked;
        int                 n_act [3];

        function new();
            en = 0; rate = 0; period = 0;
            last_frame = 0; next_dl = 0; sleep_start = 0;
            planned = 0; margin = 0; wslot = 0; fill = 0; fails = 0; seen_rate = 0;
            errors = 0; checked = 0;
            n_act = '{0, 0, 0};
        endfunction

        function bit [31:0] kth_largest(int k);
            int g, a;
            for (int i = 0; i < fill; i++)
            begin
                g = 0; a = 0;
                for (int j = 0; j < fill; j++)
                begin
                    if (ring[j] > ring[i]) g++;
                    if (ring[j] >= ring[i]) a++;
                end
                if (g <= k && k < a) return ring[i];
            end
            return 0;
        endfunction

        function bit [31:0] least_latency();
            bit [31:0] m;
            m = 32'hFFFF_FFFF;
            for (int i = 0; i < fill; i++)
                if (ring[i] < m) m = ring[i];
            return m;
        endfunction

        function pacer_result_t make(logic [ACT_W-1:0] act, longint unsigned w,
                                     longint unsigned dl);
            pacer_result_t r;
            r.action = act;
            r.wait_ns = w[31:0];
            r.deadline_ns = dl[47:0];
            r.margin_ns = margin;
            return r;
        endfunction

        function pacer_result_t pace(longint unsigned t);
            longint unsigned nxt, till, w;
            if (!en || rate == 0) return make(ACT_PROCEED, 0, t);
            if (rate != seen_rate)
            begin
                margin = 0; fill = 0; wslot = 0; seen_rate = rate;
            end
            nxt = last_frame + period;
            if (nxt > MASK48) nxt = MASK48;
            next_dl = nxt;
            if (t >= nxt)
            begin
                last_frame = t;
                return make(ACT_PROCEED, 0, nxt);
            end
            till = nxt - t;
            if (till > margin)
            begin
                w = till - margin;
                if (w > MASK32) w = MASK32;
                planned = w[31:0];
                sleep_start = t;
                return make(ACT_SLEEP, w, nxt);
            end
            fails++;
            if (fails > rate)
            begin
                fails = 0;
                if (fill == 0)
                    margin = 0;
                else if (64'(least_latency()) * 3 < 64'(period) * 2)
                    margin = 32'((64'(margin) * 9) / 10);
            end
            last_frame = nxt;
            return make(ACT_SPIN, 0, nxt);
        endfunction

        function pacer_result_t wake(longint unsigned t);
            longint unsigned el, lat, v;
            if (planned == 0) return make(ACT_PROCEED, 0, next_dl);
            el = (t > sleep_start) ? t - sleep_start : 0;
            lat = (el > planned) ? el - planned : 0;
            if (lat > MASK32) lat = MASK32;
            ring[wslot] = lat[31:0];
            wslot = (wslot + 1) % RING_DEPTH;
            if (fill < RING_DEPTH) fill++;
            if (fill * 10 >= RING_DEPTH)
            begin
                v = kth_largest(fill / 100);
                v = v + v / 2;
                if (v > MASK32) v = MASK32;
                margin = v[31:0];
            end
            fails = 0;
            planned = 0;
            if (t < next_dl)
            begin
                last_frame = next_dl;
                return make(ACT_SPIN, 0, next_dl);
            end
            last_frame = t;
            return make(ACT_PROCEED, 0, next_dl);
        endfunction

        function pacer_result_t note_request(bit cmd, longint unsigned t);
            pacer_result_t r;
            r = (cmd == CMD_PACE) ? pace(t & MASK48) : wake(t & MASK48);
            pending = {pending, r};
            n_act[r.action]++;
            return r;
        endfunction

        function void check_result(pacer_result_t got);
            pacer_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with none expected: action %0d deadline %0d",
                       got.action, got.deadline_ns);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            checked++;
            if (got.action !== e.action)
            begin
                $error("action: expected %0d, got %0d", e.action, got.action);
                errors++;
            end
            if (got.wait_ns !== e.wait_ns)
            begin
                $error("wait_ns: expected %0d, got %0d", e.wait_ns, got.wait_ns);
                errors++;
            end
            if (got.deadline_ns !== e.deadline_ns)
            begin
                $error("deadline_ns: expected %0d, got %0d", e.deadline_ns, got.deadline_ns);
                errors++;
            end
            if (got.margin_ns !== e.margin_ns)
            begin
                $error("margin_ns: expected %0d, got %0d", e.margin_ns, got.margin_ns);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    fpam_in_if  in_ch ();
    fpam_out_if out_ch ();

    frame_pacer_adaptive_margin u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    pacer_scoreboard sb;
    int              idle_mode;
    int              rx_hold;
    int              n_sent;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #15_000_000;
        $display("frame_pacer_adaptive_margin test failed");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ch.ready = 1'b0;
            rx_hold--;
        end
        else if (idle_mode == 2)
            out_ch.ready = ($urandom_range(0, 99) >= 63);
        else if (idle_mode == 3)
            out_ch.ready = ($urandom_range(0, 99) >= 6);
        else
            out_ch.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.action, out_ch.wait_ns, out_ch.deadline_ns,
                             out_ch.margin_ns});
    end

    task automatic send_request(input bit cmd, input longint unsigned t,
                                output pacer_result_t res);
        int gap;
        @(negedge clk);
        gap = 0;
        if (idle_mode == 1)
            while ($urandom_range(0, 99) < 63) gap++;
        else if (idle_mode == 3)
            while ($urandom_range(0, 99) < 6) gap++;
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.command = cmd;
        in_ch.time_ns = t[47:0];
        in_ch.valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready) break;
            @(negedge clk);
        end
        res = sb.note_request(cmd, t);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = PADDR_W'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_ENABLED: sb.en = val[0];
            REG_RATE:    sb.rate = val[RATE_W-1:0];
            default:     sb.period = val[PERIOD_W-1:0];
        endcase
    endtask

    task automatic configure(input bit en, input int rate, input int per);
        write_reg(REG_ENABLED, 32'(en));
        write_reg(REG_RATE, 32'(rate));
        write_reg(REG_PERIOD, 32'(per));
    endtask

    function automatic longint unsigned sat48(longint unsigned v);
        return (v > MASK48) ? MASK48 : v;
    endfunction

    task automatic run_phase(input int count, input longint unsigned base,
                             input int per, input int lat_cap);
        longint unsigned now, w, back;
        pacer_result_t   res, res2;
        int              r, sent0;
        now = base;
        sent0 = n_sent;
        while (n_sent - sent0 < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                send_request(CMD_PACE, now, res);
                if (res.action == ACT_SLEEP)
                begin
                    if ($urandom_range(0, 9) < 8)
                        w = now + res.wait_ns + $urandom_range(0, lat_cap);
                    else
                        w = now + $urandom_range(0, res.wait_ns) + $urandom_range(0, per);
                    w = sat48(w);
                    send_request(CMD_WAKE, w, res2);
                    now = w;
                end
                if ($urandom_range(0, 99) < 35)
                begin
                    back = $urandom_range(0, res.margin_ns + 3);
                    now = sat48(64'(res.deadline_ns) + per);
                    now = (now > back) ? now - back : 0;
                end
                else
                    now = sat48(now + $urandom_range(0, per));
            end
            else if (r < 88)
            begin
                now = sat48(now + $urandom_range(0, per));
                send_request(CMD_PACE, now, res);
            end
            else if (r < 95)
                send_request(CMD_WAKE, sat48(now + $urandom_range(0, 2 * per + 10)), res);
            else
                send_request(1'($urandom_range(0, 1)), {$urandom, $urandom} & MASK48, res);
        end
        drain();
    endtask

    initial
    begin
        pacer_result_t res;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.command = CMD_PACE; in_ch.time_ns = '0;
        out_ch.ready = 1'b0;
        idle_mode = 0; rx_hold = 0; n_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pacing off, then rate 1000 with period 1_000_000_000 and edge cases
        send_request(CMD_PACE, 0, res);
        send_request(CMD_PACE, MASK48, res);
        send_request(CMD_WAKE, 48'h5555_5555_5555, res);
        drain();
        configure(1'b1, 1000, 1_000_000_000);
        send_request(CMD_PACE, 0, res);
        send_request(CMD_WAKE, 64'(res.wait_ns) + 7, res);
        send_request(CMD_PACE, 100, res);
        send_request(CMD_WAKE, 50, res);
        send_request(CMD_WAKE, 60, res);
        send_request(CMD_PACE, MASK48, res);
        send_request(CMD_PACE, MASK48 - 5, res);
        send_request(CMD_PACE, 48'hAAAA_AAAA_AAAA, res);
        drain();
        configure(1'b1, 1, 0);
        send_request(CMD_PACE, 3, res);
        send_request(CMD_PACE, 0, res);
        drain();
        configure(1'b0, 1, 5000);
        send_request(CMD_PACE, 77, res);
        drain();
        configure(1'b1, 0, 5000);
        send_request(CMD_PACE, 78, res);
        drain();

        // random phases over a range of settings and idle patterns
        configure(1'b1, 1, 20_000);
        run_phase(200, 0, 20_000, 3_000);
        idle_mode = 1;
        configure(1'b1, 3, 50_000);
        run_phase(180, {$urandom, $urandom} & MASK48, 50_000, 8_000);
        idle_mode = 2;
        configure(1'b1, 1000, 8_000);
        rx_hold = 700;
        run_phase(180, 0, 8_000, 1_500);
        idle_mode = 3;
        configure(1'b1, 2, 30_000);
        run_phase(180, MASK48 - 64'd400_000, 30_000, 4_000);
        idle_mode = 0;
        configure(1'b1, $urandom_range(1, 1000), 1_000_000_000);
        run_phase(120, {$urandom, $urandom} & MASK48, 1_000_000_000, 50_000);
        idle_mode = 1;
        configure(1'b0, 5, 10_000);
        run_phase(60, 0, 10_000, 2_000);
        idle_mode = 2;
        configure(1'b1, 5, 10_000);
        run_phase(180, 1000, 10_000, 2_000);
        idle_mode = 3;
        configure(1'b1, 1, 1);
        run_phase(60, 0, 1, 3);
        idle_mode = 0;
        configure(1'b1, 7, 40_000);
        run_phase(200, {$urandom, $urandom} & MASK48, 40_000, 6_000);

        $display("%0d requests sent, %0d results checked (proceed %0d, sleep %0d, spin %0d)",
                 n_sent, sb.checked, sb.n_act[0], sb.n_act[1], sb.n_act[2]);
        $display("covered pacing off, late frames, deadline saturation, margin growth and shrink");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("frame_pacer_adaptive_margin test passed");
        else
            $display("frame_pacer_adaptive_margin test failed");
        $finish;
    end
endmodule
